/* hw/rtl/ibs_pkg.sv */
// ----------------------------------------------------------------------------
// Incremental bounding sphere package
// Shared payload types and arithmetic constants for the bounding sphere block.
// ----------------------------------------------------------------------------
package ibs_pkg;

    // One input item: sphere centre, radius and restart flag.
    typedef struct packed {
        logic signed [31:0] item_x;
        logic signed [31:0] item_y;
        logic signed [31:0] item_z;
        logic signed [31:0] item_radius;
        logic               restart;
    } ibs_item_t;

    // One result: the current bounding sphere.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] bound_radius;
        logic               is_empty;
    } ibs_result_t;

    localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;
    // Root digits for a 66-bit sum of squares, two radicand bits per step.
    localparam int          SQRT_STEPS = 33;
    // Quotient bits of one centre step; the step never exceeds a 32-bit magnitude.
    localparam int          DIV_STEPS  = 32;
    localparam logic [1:0]  AXIS_LAST  = 2'd2;

endpackage

/* hw/rtl/incremental_bounding_sphere.sv */
// ----------------------------------------------------------------------------
// Incremental bounding sphere
// Folds one sphere per item into a running bounding sphere, using a single
// shared multiplier, a digit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                    Payload
//  s_        in         s_valid, s_ready, s_item    ibs_item_t
//  m_        out        m_valid, m_ready, m_result  ibs_result_t
//  cfg       in         cfg_we, cfg_wdata           grow_mode
//
//  A negative item, or one that meets an empty sphere, has its result valid
//  on the cycle after its transfer. Any other item squares and sums the
//  differences on each axis, runs 33 root steps, then takes a decision step.
//  A growing item in centre-moving mode then multiplies, divides and applies per axis.
//  Reset (aresetn low, synchronous) gives an empty sphere and grow_mode 0.
//  s_ready is high only while idle; the result holds until m_ready takes it.
// ----------------------------------------------------------------------------
module incremental_bounding_sphere
    import ibs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ibs_item_t   s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output ibs_result_t m_result,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT, ST_DECIDE,
        ST_DMUL, ST_DIV, ST_APPLY, ST_OUT
    } state_t;

    state_t             state_reg;
    logic               mode_reg;
    ibs_item_t          item_reg;
    logic signed [31:0] center_reg [3];
    logic        [30:0] radius_reg;
    logic               empty_reg;
    logic        [1:0]  axis_reg;
    logic        [5:0]  cnt_reg;
    logic        [65:0] acc_reg;
    logic        [65:0] prod_reg;
    logic        [34:0] rem_reg;
    logic        [32:0] root_reg;
    logic        [31:0] quot_reg;
    logic        [33:0] delta_reg;
    logic               neg_reg;

    logic signed [31:0] item_axis;
    logic signed [32:0] diff;
    logic        [32:0] mag33;
    logic        [31:0] mag;
    logic        [33:0] mul_a;
    logic        [65:0] prod;
    logic        [36:0] rem_sh;
    logic        [36:0] trial;
    logic               sq_ge;
    logic        [34:0] dsh;
    logic        [34:0] dist_div;
    logic               d_ge;
    logic        [34:0] dist35;
    logic        [34:0] r35;
    logic        [34:0] ir35;
    logic        [34:0] sum_dr;
    logic        [34:0] sum_di;
    logic        [34:0] total;
    logic        [33:0] nr;
    logic        [33:0] delta;
    logic        [30:0] nr_sat;
    logic        [30:0] reach_sat;

    // Axis difference, item minus centre, and its magnitude.
    always_comb begin
        case (axis_reg)
            2'd0:    item_axis = item_reg.item_x;
            2'd1:    item_axis = item_reg.item_y;
            default: item_axis = item_reg.item_z;
        endcase
        diff  = {item_axis[31], item_axis} - {center_reg[axis_reg][31], center_reg[axis_reg]};
        mag33 = diff[32] ? (33'd0 - diff) : diff;
        mag   = mag33[31:0];
    end

    // Shared multiplier: squares first, then radius growth times magnitude.
    assign mul_a = (state_reg == ST_SQ_MUL) ? {2'b00, mag} : delta_reg;
    assign prod  = 66'(mul_a) * 66'(mag);

    // One digit of the square root.
    assign rem_sh = {rem_reg, acc_reg[65:64]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    // One bit of the restoring division by the distance.
    assign dsh      = {rem_reg[33:0], acc_reg[31]};
    assign dist_div = {2'b00, root_reg};
    assign d_ge     = dsh >= dist_div;

    // Growth decision terms.
    always_comb begin
        dist35    = {2'b00, root_reg};
        r35       = {4'b0000, radius_reg};
        ir35      = {4'b0000, item_reg.item_radius[30:0]};
        sum_dr    = dist35 + r35;
        sum_di    = dist35 + ir35;
        total     = sum_dr + ir35;
        nr        = total[34:1];
        delta     = nr - {3'b000, radius_reg};
        nr_sat    = (nr > {3'b000, RADIUS_MAX}) ? RADIUS_MAX : nr[30:0];
        reach_sat = (sum_di > {4'b0000, RADIUS_MAX}) ? RADIUS_MAX : sum_di[30:0];
    end

    // Sequencer and sphere state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= 1'b0;
            center_reg <= '{3{32'sd0}};
            radius_reg <= '0;
            empty_reg  <= 1'b1;
            axis_reg   <= '0;
            cnt_reg    <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_item;
                        axis_reg <= '0;
                        acc_reg  <= '0;
                        if (s_item.restart) begin
                            center_reg <= '{3{32'sd0}};
                            radius_reg <= '0;
                            empty_reg  <= 1'b1;
                        end
                        if (s_item.item_radius[31]) begin
                            state_reg <= ST_OUT;
                        end else if (s_item.restart || empty_reg) begin
                            center_reg[0] <= s_item.item_x;
                            center_reg[1] <= s_item.item_y;
                            center_reg[2] <= s_item.item_z;
                            radius_reg    <= s_item.item_radius[30:0];
                            empty_reg     <= 1'b0;
                            state_reg     <= ST_OUT;
                        end else begin
                            state_reg <= ST_SQ_MUL;
                        end
                    end
                end
                ST_SQ_MUL: begin
                    prod_reg  <= prod;
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC: begin
                    acc_reg <= acc_reg + prod_reg;
                    if (axis_reg == AXIS_LAST) begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_SQRT: begin
                    rem_reg  <= sq_ge ? 35'(rem_sh - trial) : rem_sh[34:0];
                    root_reg <= {root_reg[31:0], sq_ge};
                    acc_reg  <= {acc_reg[63:0], 2'b00};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SQRT_STEPS - 1)) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    axis_reg  <= '0;
                    state_reg <= ST_OUT;
                    if (mode_reg) begin
                        if (r35 < sum_di) begin
                            radius_reg <= reach_sat;
                        end
                    end else if (!(ir35 < sum_dr)) begin
                        // The item encloses the sphere and replaces it.
                        center_reg[0] <= item_reg.item_x;
                        center_reg[1] <= item_reg.item_y;
                        center_reg[2] <= item_reg.item_z;
                        radius_reg    <= item_reg.item_radius[30:0];
                    end else if (r35 < sum_di) begin
                        delta_reg  <= delta;
                        radius_reg <= nr_sat;
                        state_reg  <= ST_DMUL;
                    end
                end
                ST_DMUL: begin
                    rem_reg   <= {1'b0, prod[65:32]};
                    acc_reg   <= {34'd0, prod[31:0]};
                    neg_reg   <= diff[32];
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= d_ge ? (dsh - dist_div) : dsh;
                    quot_reg <= {quot_reg[30:0], d_ge};
                    acc_reg  <= {acc_reg[64:0], 1'b0};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    center_reg[axis_reg] <= neg_reg ? (center_reg[axis_reg] - quot_reg)
                                                    : (center_reg[axis_reg] + quot_reg);
                    if (axis_reg == AXIS_LAST) begin
                        state_reg <= ST_OUT;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_DMUL;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Handshake outputs and result payload.
    assign s_ready               = (state_reg == ST_IDLE);
    assign m_valid               = (state_reg == ST_OUT);
    assign m_result.center_x     = center_reg[0];
    assign m_result.center_y     = center_reg[1];
    assign m_result.center_z     = center_reg[2];
    assign m_result.bound_radius = radius_reg;
    assign m_result.is_empty     = empty_reg;

`ifndef ASSERT_OFF
    // An empty sphere always has zero centre and radius.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (radius_reg == '0 && center_reg[0] == '0 &&
                       center_reg[1] == '0 && center_reg[2] == '0))
        else $error("empty sphere holds nonzero state");

    // The block never takes an item while a result is on offer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result valid");

    // A negative item leaves the sphere untouched apart from restart.
    a_neg_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.item_radius[31] && !s_item.restart)
        |=> $stable(radius_reg) && $stable(empty_reg) && m_valid)
        else $error("negative item changed the sphere");

    // Division magnitude never overflows its remainder range.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {2'b00, root_reg}))
        else $error("division remainder out of range");
`endif

endmodule
